### design/hsb_pkg.sv
// Shared types and constants of the heart segment binning block.
`timescale 1ns / 1ps
package hsb_pkg;

    localparam int NODE_DEPTH  = 32768;
    localparam int NODE_AW     = $clog2(NODE_DEPTH);
    localparam int COORD_WIDTH = 24;
    localparam int SEG_COUNT   = 17;
    localparam int SEG_AW      = 5;
    localparam int LABEL_W     = 5;
    localparam int ACC_W       = 48;
    localparam int ADD_W       = 36;   // (24 x 32 product) >> 20
    localparam int NODE_W      = LABEL_W + 3 * COORD_WIDTH;

    localparam logic [LABEL_W-1:0] LABEL_APEX = 5'd17;

    localparam logic signed [COORD_WIDTH-1:0] BASE_RESET = 24'sd291924;
    localparam logic signed [COORD_WIDTH-1:0] MID_RESET  = 24'sd185296;
    localparam logic signed [COORD_WIDTH-1:0] APEX_RESET = 24'sd78669;

    typedef enum logic [1:0] {
        CMD_NODE = 2'd0,
        CMD_ELEM = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_BASE = 2'd0,
        CFG_MID  = 2'd1,
        CFG_APEX = 2'd2,
        CFG_NONE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] base;
        logic signed [COORD_WIDTH-1:0] mid;
        logic signed [COORD_WIDTH-1:0] apex;
    } t_planes;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NCLS,
        ST_NWR,
        ST_ERD,
        ST_ECAP,
        ST_VOTE,
        ST_DSQ,
        ST_DCMP,
        ST_MUL,
        ST_AWR,
        ST_RRD,
        ST_RRES,
        ST_DONE
    } t_state;

endpackage

### design/hsb_classify.sv
// Node labeler: registered coordinate squares, then plane and sector tests.
`timescale 1ns / 1ps
module hsb_classify (
    input  logic                                   i_clk,
    input  logic signed [hsb_pkg::COORD_WIDTH-1:0] i_x,
    input  logic signed [hsb_pkg::COORD_WIDTH-1:0] i_y,
    input  logic signed [hsb_pkg::COORD_WIDTH-1:0] i_z,
    input  hsb_pkg::t_planes                       i_planes,
    output logic [hsb_pkg::LABEL_W-1:0]            o_label
);
    import hsb_pkg::*;

    localparam int SQ_W = 2 * COORD_WIDTH;

    logic [COORD_WIDTH-1:0] w_xmag, w_ymag;
    logic [SQ_W-1:0]        r_xsq, r_ysq;
    logic [SQ_W+1:0]        w_x3;
    logic                   w_lt;
    logic [2:0]             w_s6;
    logic [1:0]             w_s4;

    // x and y are held by the caller, so the registered squares line up with them
    assign w_xmag = i_x[COORD_WIDTH-1] ? COORD_WIDTH'(-i_x) : COORD_WIDTH'(i_x);
    assign w_ymag = i_y[COORD_WIDTH-1] ? COORD_WIDTH'(-i_y) : COORD_WIDTH'(i_y);

    always_ff @(posedge i_clk) begin
        r_xsq <= SQ_W'(w_xmag) * SQ_W'(w_xmag);
        r_ysq <= SQ_W'(w_ymag) * SQ_W'(w_ymag);
    end

    // |y| < |x| * tan(60): steep sectors otherwise
    assign w_x3 = {1'b0, r_xsq, 1'b0} + {2'b00, r_xsq};
    assign w_lt = {2'b00, r_ysq} < w_x3;

    always_comb begin
        // phi measured counterclockwise from the negative x axis
        if (i_y == '0) begin
            w_s6 = i_x[COORD_WIDTH-1] ? 3'd5 : 3'd3;
            w_s4 = i_x[COORD_WIDTH-1] ? 2'd3 : 2'd2;
        end else if (i_y[COORD_WIDTH-1]) begin
            w_s6 = w_lt ? (i_x[COORD_WIDTH-1] ? 3'd0 : 3'd2) : 3'd1;
            w_s4 = i_x[COORD_WIDTH-1] ? 2'd0 : 2'd1;
        end else begin
            w_s6 = w_lt ? ((!i_x[COORD_WIDTH-1] && i_x != '0) ? 3'd3 : 3'd5) : 3'd4;
            w_s4 = (!i_x[COORD_WIDTH-1] && i_x != '0) ? 2'd2 : 2'd3;
        end
    end

    always_comb begin
        priority if (i_z > i_planes.base) begin
            o_label = LABEL_W'(5'd1 + {2'b00, w_s6});
        end else if (i_z > i_planes.mid) begin
            o_label = LABEL_W'(5'd7 + {2'b00, w_s6});
        end else if (i_z > i_planes.apex) begin
            o_label = LABEL_W'(5'd13 + {3'b000, w_s4});
        end else begin
            o_label = LABEL_APEX;
        end
    end

endmodule

### design/heart_segment_binning.sv
// Top level: node memory, segment accumulators and the item sequencer.
`timescale 1ns / 1ps
// Bins mesh nodes and tetrahedral elements into the 17 ventricle segments.
// A node item (tuser 0) labels the node from its height and angle and stores
// label and coordinates in a single-port node memory (32768 x 77). An element
// item (tuser 1) reads its four corners one per memory access, takes the
// majority label (nearest-to-centroid corner on 2-2 or all-distinct votes)
// and adds (J * volume) >> 20 to that segment's 48-bit accumulator,
// saturating. A read item (tuser 2) returns one accumulator; tuser 3 returns
// zeros. One item is worked at a time; the next is taken once the last
// result is loaded into the output register. Element timing is set by the
// single node memory port (a read and a capture step per corner) and, when
// the vote goes to the distance test, by the shared set of three squarers
// used once per corner. Accumulators start at zero after reset through
// per-entry valid bits; no clearing pass is needed. Node entries never
// written read as garbage. Config writes (planes, Q8.16) are always
// accepted; make them only while no item is in flight.
module heart_segment_binning (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write: index 0 base plane, 1 mid plane, 2 apex plane
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [23:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: node_index[15], x_pos[24], y_pos[24], z_pos[24],
    // corner_a..corner_d[15 each], jacobian_value[24], ref_volume[32],
    // segment_select[5]
    input  logic [207:0] s_axis_tdata,
    // tuser: cmd[2]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata from bit 0: segment[5], volume_total[48], zero fill[3]
    output logic [55:0]  m_axis_tdata
);
    import hsb_pkg::*;

    localparam int SUM_W  = COORD_WIDTH + 2;   // sum of four corners
    localparam int DIFF_W = COORD_WIDTH + 3;
    localparam int DSQ_W  = 2 * DIFF_W;
    localparam int DIST_W = DSQ_W + 2;

    // ---------------- config registers ----------------
    t_planes r_planes;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planes.base <= BASE_RESET;
            r_planes.mid  <= MID_RESET;
            r_planes.apex <= APEX_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BASE: r_planes.base <= i_cfg_data;
                CFG_MID:  r_planes.mid  <= i_cfg_data;
                CFG_APEX: r_planes.apex <= i_cfg_data;
                CFG_NONE: ;
            endcase
        end
    end

    // ---------------- held item ----------------
    logic [NODE_AW-1:0]            r_idx;
    logic signed [COORD_WIDTH-1:0] r_x, r_y, r_z;
    logic [NODE_AW-1:0]            r_corner [4];
    logic [23:0]                   r_j;
    logic [31:0]                   r_vol;
    logic [SEG_AW-1:0]             r_sel;

    t_state r_state, n_state;
    logic   w_accept;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx       <= s_axis_tdata[14:0];
            r_x         <= s_axis_tdata[38:15];
            r_y         <= s_axis_tdata[62:39];
            r_z         <= s_axis_tdata[86:63];
            r_corner[0] <= s_axis_tdata[101:87];
            r_corner[1] <= s_axis_tdata[116:102];
            r_corner[2] <= s_axis_tdata[131:117];
            r_corner[3] <= s_axis_tdata[146:132];
            r_j         <= s_axis_tdata[170:147];
            r_vol       <= s_axis_tdata[202:171];
            r_sel       <= s_axis_tdata[207:203];
        end
    end

    // ---------------- node labeler ----------------
    logic [LABEL_W-1:0] w_label;

    hsb_classify u_classify (
        .i_clk    (i_clk),
        .i_x      (r_x),
        .i_y      (r_y),
        .i_z      (r_z),
        .i_planes (r_planes),
        .o_label  (w_label)
    );

    // ---------------- node memory, single port ----------------
    logic [NODE_W-1:0]  r_node_mem [NODE_DEPTH];
    logic [NODE_W-1:0]  r_node_q;
    logic [NODE_AW-1:0] w_node_addr;
    logic               w_node_we;
    logic [1:0]         r_k;

    assign w_node_we   = (r_state == ST_NWR);
    assign w_node_addr = w_node_we ? r_idx : r_corner[r_k];

    always_ff @(posedge i_clk) begin
        if (w_node_we) begin
            r_node_mem[w_node_addr] <= {w_label, r_x, r_y, r_z};
        end else begin
            r_node_q <= r_node_mem[w_node_addr];
        end
    end

    // ---------------- accumulator memory ----------------
    logic [ACC_W-1:0]     r_acc_mem [SEG_COUNT];
    logic [SEG_COUNT-1:0] r_acc_vld;
    logic [ACC_W-1:0]     r_acc_q;
    logic                 r_acc_qv;
    logic [SEG_AW-1:0]    w_acc_addr;
    logic                 w_acc_we;
    logic [ACC_W-1:0]     w_acc_wdata;
    logic [LABEL_W-1:0]   r_best;
    logic                 w_best_ok;

    assign w_best_ok  = (r_best >= LABEL_W'(1)) && (r_best <= LABEL_W'(SEG_COUNT));
    assign w_acc_addr = (r_state == ST_RRD) ? r_sel : SEG_AW'(r_best - LABEL_W'(1));
    assign w_acc_we   = (r_state == ST_AWR);

    always_ff @(posedge i_clk) begin
        if (w_acc_we) begin
            r_acc_mem[w_acc_addr] <= w_acc_wdata;
        end
        r_acc_q  <= r_acc_mem[w_acc_addr];
        r_acc_qv <= (w_acc_addr < SEG_AW'(SEG_COUNT)) && r_acc_vld[w_acc_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= '0;
        end else if (w_acc_we) begin
            r_acc_vld[w_acc_addr] <= 1'b1;
        end
    end

    // ---------------- corner capture ----------------
    logic [LABEL_W-1:0]            r_lab [4];
    logic signed [COORD_WIDTH-1:0] r_px [4], r_py [4], r_pz [4];
    logic signed [SUM_W-1:0]       r_sx, r_sy, r_sz;
    logic signed [COORD_WIDTH-1:0] w_qx, w_qy, w_qz;

    assign w_qx = r_node_q[3*COORD_WIDTH-1:2*COORD_WIDTH];
    assign w_qy = r_node_q[2*COORD_WIDTH-1:COORD_WIDTH];
    assign w_qz = r_node_q[COORD_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sx <= '0;
            r_sy <= '0;
            r_sz <= '0;
        end else if (r_state == ST_ECAP) begin
            r_lab[r_k] <= r_node_q[NODE_W-1:3*COORD_WIDTH];
            r_px[r_k]  <= w_qx;
            r_py[r_k]  <= w_qy;
            r_pz[r_k]  <= w_qz;
            r_sx       <= r_sx + SUM_W'(w_qx);
            r_sy       <= r_sy + SUM_W'(w_qy);
            r_sz       <= r_sz + SUM_W'(w_qz);
        end
    end

    // ---------------- vote ----------------
    logic [2:0]         w_cnt [4];
    logic               w_any3;
    logic [2:0]         w_n2;
    logic [LABEL_W-1:0] w_lab3, w_lab2;

    always_comb begin
        w_any3 = 1'b0;
        w_n2   = '0;
        w_lab3 = r_lab[0];
        w_lab2 = r_lab[0];
        for (int i = 0; i < 4; i++) begin
            w_cnt[i] = '0;
            for (int j = 0; j < 4; j++) begin
                w_cnt[i] = w_cnt[i] + {2'b00, r_lab[i] == r_lab[j]};
            end
        end
        for (int i = 3; i >= 0; i--) begin
            if (w_cnt[i] >= 3'd3) begin
                w_any3 = 1'b1;
                w_lab3 = r_lab[i];
            end
            if (w_cnt[i] == 3'd2) begin
                w_n2   = w_n2 + 3'd1;
                w_lab2 = r_lab[i];
            end
        end
    end

    // ---------------- nearest corner to centroid ----------------
    logic signed [DIFF_W-1:0] w_dx, w_dy, w_dz;
    logic [DIFF_W-1:0]        w_mx, w_my, w_mz;
    logic [DSQ_W-1:0]         r_sqx, r_sqy, r_sqz;
    logic [DIST_W-1:0]        w_dist, r_bd;

    assign w_dx = {r_px[r_k][COORD_WIDTH-1], r_px[r_k], 2'b00} - DIFF_W'(r_sx);
    assign w_dy = {r_py[r_k][COORD_WIDTH-1], r_py[r_k], 2'b00} - DIFF_W'(r_sy);
    assign w_dz = {r_pz[r_k][COORD_WIDTH-1], r_pz[r_k], 2'b00} - DIFF_W'(r_sz);
    assign w_mx = w_dx[DIFF_W-1] ? DIFF_W'(-w_dx) : DIFF_W'(w_dx);
    assign w_my = w_dy[DIFF_W-1] ? DIFF_W'(-w_dy) : DIFF_W'(w_dy);
    assign w_mz = w_dz[DIFF_W-1] ? DIFF_W'(-w_dz) : DIFF_W'(w_dz);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DSQ) begin
            r_sqx <= DSQ_W'(w_mx) * DSQ_W'(w_mx);
            r_sqy <= DSQ_W'(w_my) * DSQ_W'(w_my);
            r_sqz <= DSQ_W'(w_mz) * DSQ_W'(w_mz);
        end
    end

    assign w_dist = DIST_W'(r_sqx) + DIST_W'(r_sqy) + DIST_W'(r_sqz);

    // ---------------- product and saturating add ----------------
    logic [55:0]      w_prod;
    logic [ADD_W-1:0] r_add;
    logic [ACC_W:0]   w_acc_sum;

    assign w_prod      = 56'(r_j) * 56'(r_vol);
    assign w_acc_sum   = {1'b0, (r_acc_qv ? r_acc_q : ACC_W'(0))} + (ACC_W + 1)'(r_add);
    assign w_acc_wdata = w_acc_sum[ACC_W] ? {ACC_W{1'b1}} : w_acc_sum[ACC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_add <= w_prod[20 +: ADD_W];
        end
    end

    // ---------------- sequencer ----------------
    logic [LABEL_W-1:0] r_res_seg, n_res_seg;
    logic [ACC_W-1:0]   r_res_vol, n_res_vol;
    logic [1:0]         n_k;
    logic [LABEL_W-1:0] n_best;
    logic [DIST_W-1:0]  n_bd;
    logic               r_out_valid;
    logic [LABEL_W-1:0] r_out_seg;
    logic [ACC_W-1:0]   r_out_vol;
    logic               w_slot;

    assign w_slot = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_best    <= n_best;
        r_bd      <= n_bd;
        r_res_seg <= n_res_seg;
        r_res_vol <= n_res_vol;
    end

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_best    = r_best;
        n_bd      = r_bd;
        n_res_seg = r_res_seg;
        n_res_vol = r_res_vol;
        unique case (r_state)
            ST_IDLE: begin
                n_k       = '0;
                n_res_seg = '0;
                n_res_vol = '0;
                if (w_accept) begin
                    unique case (t_cmd'(s_axis_tuser))
                        CMD_NODE: n_state = ST_NCLS;
                        CMD_ELEM: n_state = ST_ERD;
                        CMD_READ: n_state = ST_RRD;
                        CMD_NONE: n_state = ST_DONE;
                    endcase
                end
            end
            ST_NCLS: n_state = ST_NWR;
            ST_NWR: begin
                n_res_seg = w_label;
                n_state   = ST_DONE;
            end
            ST_ERD:  n_state = ST_ECAP;
            ST_ECAP: begin
                n_k = r_k + 2'd1;
                n_state = (r_k == 2'd3) ? ST_VOTE : ST_ERD;
            end
            ST_VOTE: begin
                n_k = '0;
                priority if (w_any3) begin
                    n_best  = w_lab3;
                    n_state = ST_MUL;
                end else if (w_n2 == 3'd2) begin
                    n_best  = w_lab2;
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_DSQ;
                end
            end
            ST_DSQ: n_state = ST_DCMP;
            ST_DCMP: begin
                if (r_k == 2'd0 || w_dist < r_bd) begin
                    n_bd   = w_dist;
                    n_best = r_lab[r_k];
                end
                n_k = r_k + 2'd1;
                n_state = (r_k == 2'd3) ? ST_MUL : ST_DSQ;
            end
            ST_MUL: begin
                n_res_seg = r_best;
                n_state   = w_best_ok ? ST_AWR : ST_DONE;
            end
            ST_AWR:  n_state = ST_DONE;
            ST_RRD:  n_state = ST_RRES;
            ST_RRES: begin
                n_res_vol = r_acc_qv ? r_acc_q : '0;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (w_slot) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && w_slot) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_slot) begin
            r_out_seg <= r_res_seg;
            r_out_vol <= r_res_vol;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_vol, r_out_seg};

    // ---------------- checks ----------------
    a_acc_addr_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_we |-> (r_best >= LABEL_W'(1) && r_best <= LABEL_W'(SEG_COUNT)))
        else $error("accumulator write outside segment range");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("new item taken while one is in flight");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result loaded outside the done state");

    a_vld_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 ((r_acc_vld & $past(r_acc_vld)) == $past(r_acc_vld)))
        else $error("accumulator valid bit dropped");

endmodule
